@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared types and codes for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ADDR_W     = 48;
  localparam int SHIFT_W    = 5;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int FREE_CNT_W = 7;

  // Request kinds carried on the input tuser.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_RESULT
  } state_t;

endpackage

@@ rtl/bba_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic                                            clk,
  input  logic                                            we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                                wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                                rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [0:(2**AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bitmap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Hands out and takes back fixed-size blocks of a region, lowest free first.
// ----------------------------------------------------------------------------
// Flow: a transferred request passes the read, modify and result states (RAM
// read, modify/write back, address formation); its result is loaded into the
// output register once that is free or draining, and m_tvalid rises at that
// same edge. No new request is taken until then, as the read-modify-write of
// one 64-bit bitmap word in the RAM and the address adder are not overlapped.
// Reset: control state clears at once; bitmap words read as all free through
// per-word valid flags, so no clearing pass is needed and requests are taken
// from the first cycle after reset. Neither input channel is ready in reset.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // [47:0] free_address
  input  logic [0:0]            s_tuser,   // [0] mode
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,   // [0] ok, [48:1] block_address,
                                           // [55:49] free_blocks
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data
);

  // The bitmap is kept as 64-bit words; the word slots are rounded up to a
  // power of two so a word index addresses them exactly. Slots past the last
  // real word never hold a free block.
  localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WORD_SLOTS = 2 ** WORD_W;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int LAST_BITS  = NUM_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
      (LAST_BITS == WORD_BITS) ? {WORD_BITS{1'b1}}
                               : ((64'd1 << LAST_BITS) - 64'd1);

  // Configuration registers.
  logic [ADDR_W-1:0]  region_base;
  logic [SHIFT_W-1:0] block_shift;

  // Request context.
  state_t             state, state_next;
  logic               req_mode;
  logic               req_ok;
  logic [WORD_W-1:0]  word_sel;
  logic [BIT_W-1:0]   bit_sel;
  logic [CNT_W-1:0]   count;

  // Per-word flags: written since reset, and holds at least one free block.
  logic [WORD_SLOTS-1:0] word_valid;
  logic [WORD_SLOTS-1:0] word_free;

  // Output register.
  logic               out_ok;
  logic [ADDR_W-1:0]  out_addr;
  logic [FREE_CNT_W-1:0] out_free;

  // RAM port signals.
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] ram_wdata;

  // Combinational helpers.
  logic                 accept;
  logic [ADDR_W:0]      offset;
  logic                 in_range;
  logic [ADDR_W-1:0]    idx_full;
  logic                 any_free_word;
  logic [WORD_W-1:0]    first_word;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] new_word;
  logic [BIT_W-1:0]     first_bit;
  logic                 success;
  logic [WORD_W+BIT_W-1:0] blk_index;
  logic [ADDR_W-1:0]    alloc_addr;
  logic                 out_load;
  logic [CNT_W+FREE_CNT_W-1:0] count_ext;

  assign cfg_ready = !rst;
  assign s_tready  = !rst && (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      block_shift <= SHIFT_W'(12);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_REGION_BASE) begin
        region_base <= cfg_data;
      end else if (cfg_index == REG_BLOCK_SHIFT) begin
        block_shift <= cfg_data[SHIFT_W-1:0];
      end
    end
  end

  // A free request is range checked at the transfer. The region spans
  // NUM_BLOCKS << block_shift bytes, which is compared without wrap, so an
  // in-range offset always gives a block index below NUM_BLOCKS.
  assign offset   = {1'b0, s_tdata} - {1'b0, region_base};
  assign in_range = !offset[ADDR_W] &&
                    ({16'd0, offset[ADDR_W-1:0]} < (64'(NUM_BLOCKS) << block_shift));
  assign idx_full = offset[ADDR_W-1:0] >> block_shift;

  // Lowest word that still holds a free block.
  always_comb begin
    any_free_word = |word_free;
    first_word    = '0;
    for (int w = WORD_SLOTS - 1; w >= 0; w--) begin
      if (word_free[w]) begin
        first_word = WORD_W'(w);
      end
    end
  end

  assign ram_raddr = (req_mode == MODE_ALLOC) ? first_word : word_sel;

  // A word never written since reset reads as its reset pattern: all free,
  // with the bits past the last block clear.
  always_comb begin
    if (word_valid[word_sel]) begin
      cur_word = ram_rdata;
    end else if (32'(word_sel) == MAP_WORDS - 1) begin
      cur_word = LAST_MASK;
    end else begin
      cur_word = {WORD_BITS{1'b1}};
    end
  end

  // Lowest free bit within the selected word.
  always_comb begin
    first_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cur_word[b]) begin
        first_bit = BIT_W'(b);
      end
    end
  end

  // Modify step: allocation clears the lowest free bit, a free sets the
  // addressed bit and fails if it was already set.
  always_comb begin
    new_word = cur_word;
    success  = 1'b0;
    if (req_mode == MODE_ALLOC) begin
      if (req_ok) begin
        new_word[first_bit] = 1'b0;
        success = 1'b1;
      end
    end else begin
      if (req_ok && !cur_word[bit_sel]) begin
        new_word[bit_sel] = 1'b1;
        success = 1'b1;
      end
    end
  end

  assign ram_we    = (state == ST_MODIFY) && success;
  assign ram_wdata = new_word;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_SLOTS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_sel),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The allocated address wraps at 48 bits.
  assign blk_index  = {word_sel, bit_sel};
  assign alloc_addr = region_base + (ADDR_W'(blk_index) << block_shift);
  assign out_load   = (state == ST_RESULT) && (!m_tvalid || m_tready);
  assign count_ext  = {{FREE_CNT_W{1'b0}}, count};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_READ;
      ST_READ:   state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_RESULT;
      ST_RESULT: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: bitmap flags, free count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      for (int w = 0; w < WORD_SLOTS; w++) begin
        word_free[w] <= (w < MAP_WORDS);
      end
      count    <= CNT_W'(NUM_BLOCKS);
      m_tvalid <= 1'b0;
    end else begin
      if (ram_we) begin
        word_valid[word_sel] <= 1'b1;
        word_free[word_sel]  <= |new_word;
        if (req_mode == MODE_ALLOC) begin
          count <= count - CNT_W'(1);
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request context and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= s_tuser[0];
      req_ok   <= in_range;
      bit_sel  <= idx_full[BIT_W-1:0];
      word_sel <= idx_full[BIT_W +: WORD_W];
    end
    if (state == ST_READ && req_mode == MODE_ALLOC) begin
      req_ok   <= any_free_word;
      word_sel <= first_word;
    end
    if (state == ST_MODIFY) begin
      req_ok <= success;
      if (req_mode == MODE_ALLOC) begin
        bit_sel <= first_bit;
      end
    end
    if (out_load) begin
      out_ok   <= req_ok;
      out_addr <= (req_ok && req_mode == MODE_ALLOC) ? alloc_addr : '0;
      out_free <= count_ext[FREE_CNT_W-1:0];
    end
  end

  assign m_tdata = {out_free, out_addr, out_ok};

  // The free count can never exceed the number of blocks.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_BLOCKS))
    else $error("free count above block count");

  // A failed request leaves the free count alone.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MODIFY && !success) |=> $stable(count))
    else $error("free count changed on a failed request");

  // The bitmap RAM is written only in the modify step.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_MODIFY))
    else $error("bitmap write outside modify step");

  // A new result is loaded only when the output register is free or draining.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && state == ST_RESULT) |=> (state == ST_RESULT))
    else $error("result overwritten while stalled");

endmodule
